// ----- design/fnn_pkg.sv -----
// shared types, codes and constants for the fasta nucleotide normalizer
package fnn_pkg;

	localparam int SEED_MAX    = 32;
	localparam int SEED_BITS   = 2 * SEED_MAX;
	localparam int SEED_POS_W  = $clog2(SEED_MAX);
	localparam int SEED_LEN_W  = 6;
	localparam int OFFSET_BITS = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 64;

	// register select is byte address bit 3 (registers are 8 bytes apart)
	localparam logic REG_SEED_SYMBOLS = 1'b0;
	localparam logic REG_SEED_LENGTH  = 1'b1;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_EOF  = 1'b1;

	localparam logic [1:0] KIND_SYMBOL = 2'd0;
	localparam logic [1:0] KIND_START  = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;

	localparam logic [7:0] CHAR_LF     = 8'h0A;
	localparam logic [7:0] CHAR_GT     = 8'h3E;
	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_A      = 8'h41;
	localparam logic [7:0] CHAR_C      = 8'h43;
	localparam logic [7:0] CHAR_G      = 8'h47;
	localparam logic [7:0] CHAR_T      = 8'h54;
	localparam logic [7:0] CHAR_LOW_A  = 8'h61;
	localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
	localparam logic [7:0] CASE_DIFF   = 8'h20;

	typedef struct packed {
		logic       command;
		logic [7:0] in_byte;
	} fnn_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  symbol;
		logic [31:0] offset;
		logic        last;
	} fnn_out_t;

	typedef enum logic [1:0] {
		OP_SYM,
		OP_START,
		OP_EOF
	} fnn_op_t;

	// one queued job: a symbol, a start offset, or the end-of-file triple
	typedef struct packed {
		fnn_op_t                op;
		logic [7:0]             symbol;
		logic [OFFSET_BITS-1:0] off_a;
		logic [OFFSET_BITS-1:0] off_b;
	} fnn_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fnn_qstat_t;

endpackage

// ----- design/fnn_front.sv -----
// front end: accepts file bytes, tracks line state and seed, queues jobs
module fnn_front import fnn_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  fnn_in_t               byte_data,
	input  logic [SEED_BITS-1:0]  seed_symbols,
	input  logic [SEED_LEN_W-1:0] seed_length,
	input  fnn_qstat_t            qstat,
	output logic                  push,
	output fnn_entry_t            push_entry
);

	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

	logic                   at_line_start_q, at_line_start_d;
	logic                   in_header_q, in_header_d;
	logic [SEED_POS_W-1:0]  seed_pos_q, seed_pos_d;
	logic [OFFSET_BITS-1:0] text_count_q, text_count_d;
	logic [OFFSET_BITS-1:0] seq_start_q, seq_start_d;

	logic                  accept;
	logic [7:0]            raw;
	logic [7:0]            upper;
	logic                  is_base;
	logic [SEED_LEN_W-1:0] len_eff;
	logic [SEED_POS_W-1:0] pos_use;
	logic [SEED_LEN_W-1:0] pos_inc;
	logic [1:0]            seed_code;
	logic [7:0]            seed_char;
	logic [7:0]            norm_char;

	assign byte_stall = qstat.full;
	assign accept     = byte_valid && !qstat.full;
	assign raw        = byte_data.in_byte;

	always_comb begin
		upper = raw;
		if (raw >= CHAR_LOW_A && raw <= CHAR_LOW_Z) begin
			upper = raw - CASE_DIFF;
		end
		is_base = (upper == CHAR_A) || (upper == CHAR_C) || (upper == CHAR_G) ||
			(upper == CHAR_T);

		len_eff = seed_length;
		if (seed_length == '0) begin
			len_eff = SEED_LEN_W'(1);
		end else if (seed_length > SEED_LEN_W'(SEED_MAX)) begin
			len_eff = SEED_LEN_W'(SEED_MAX);
		end

		// position left over from a longer seed restarts at zero
		pos_use = (SEED_LEN_W'(seed_pos_q) >= len_eff) ? '0 : seed_pos_q;
		seed_code = seed_symbols[{pos_use, 1'b0} +: 2];
		pos_inc = SEED_LEN_W'(pos_use) + SEED_LEN_W'(1);

		case (seed_code)
			2'd0:    seed_char = CHAR_A;
			2'd1:    seed_char = CHAR_C;
			2'd2:    seed_char = CHAR_G;
			default: seed_char = CHAR_T;
		endcase
		norm_char = is_base ? upper : seed_char;
	end

	always_comb begin
		at_line_start_d = at_line_start_q;
		in_header_d     = in_header_q;
		seed_pos_d      = seed_pos_q;
		text_count_d    = text_count_q;
		seq_start_d     = seq_start_q;
		push            = 1'b0;
		push_entry.op     = OP_SYM;
		push_entry.symbol = norm_char;
		push_entry.off_a  = seq_start_q;
		push_entry.off_b  = text_count_q;

		if (accept) begin
			if (byte_data.command == CMD_EOF) begin
				push            = 1'b1;
				push_entry.op   = OP_EOF;
				at_line_start_d = 1'b1;
				in_header_d     = 1'b0;
				seed_pos_d      = '0;
				text_count_d    = '0;
				seq_start_d     = '0;
			end else if (in_header_q) begin
				if (raw == CHAR_LF) begin
					in_header_d     = 1'b0;
					at_line_start_d = 1'b1;
				end
			end else if (raw == CHAR_LF) begin
				at_line_start_d = 1'b1;
			end else if (at_line_start_q && raw == CHAR_GT) begin
				in_header_d     = 1'b1;
				at_line_start_d = 1'b0;
				// previous sequence is only reported when it holds text
				if (text_count_q != seq_start_q) begin
					push          = 1'b1;
					push_entry.op = OP_START;
					seq_start_d   = text_count_q;
				end
			end else begin
				at_line_start_d = 1'b0;
				push            = 1'b1;
				push_entry.op   = OP_SYM;
				if (is_base) begin
					seed_pos_d = '0;
				end else begin
					seed_pos_d = (pos_inc >= len_eff) ? '0 : pos_inc[SEED_POS_W-1:0];
				end
				if (text_count_q != OFFSET_MAX) begin
					text_count_d = text_count_q + OFFSET_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_line_start_q <= 1'b1;
			in_header_q     <= 1'b0;
			seed_pos_q      <= '0;
			text_count_q    <= '0;
			seq_start_q     <= '0;
		end else begin
			at_line_start_q <= at_line_start_d;
			in_header_q     <= in_header_d;
			seed_pos_q      <= seed_pos_d;
			text_count_q    <= text_count_d;
			seq_start_q     <= seq_start_d;
		end
	end

endmodule

// ----- design/fnn_queue.sv -----
// small job queue between front and back ends
module fnn_queue import fnn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  fnn_entry_t push_entry,
	input  logic       pop,
	output fnn_entry_t head,
	output fnn_qstat_t qstat
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	fnn_entry_t       slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head        = slots_q[rd_ptr_q];
	assign qstat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/fnn_back.sv -----
// back end: expands queued jobs into result transfers through an output register
module fnn_back import fnn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  fnn_entry_t head,
	input  fnn_qstat_t qstat,
	output logic       pop,
	output logic       res_valid,
	input  logic       res_stall,
	output fnn_out_t   res_data
);

	logic       res_valid_q;
	fnn_out_t   res_data_q;
	logic [1:0] step_q;
	logic       load;
	logic       emit;
	logic       done;
	fnn_out_t   next_res;

	assign load      = !res_valid_q || !res_stall;
	assign emit      = load && !qstat.empty;
	assign pop       = emit && done;
	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

	always_comb begin
		next_res.kind   = KIND_SYMBOL;
		next_res.symbol = '0;
		next_res.offset = '0;
		next_res.last   = 1'b1;
		done            = 1'b1;
		case (head.op)
			OP_SYM: begin
				next_res.symbol = head.symbol;
			end
			OP_START: begin
				next_res.kind   = KIND_START;
				next_res.offset = head.off_a[31:0];
			end
			OP_EOF: begin
				// start offset, end offset, then the terminator
				case (step_q)
					2'd0: begin
						next_res.kind   = KIND_START;
						next_res.offset = head.off_a[31:0];
						next_res.last   = 1'b0;
						done            = 1'b0;
					end
					2'd1: begin
						next_res.kind   = KIND_END;
						next_res.offset = head.off_b[31:0];
						next_res.last   = 1'b0;
						done            = 1'b0;
					end
					default: begin
						next_res.symbol = CHAR_DOLLAR;
					end
				endcase
			end
			default: begin
				next_res.symbol = head.symbol;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_data_q <= next_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (load) begin
				res_valid_q <= !qstat.empty;
			end
			if (emit) begin
				step_q <= done ? 2'd0 : step_q + 2'd1;
			end
		end
	end

endmodule

// ----- design/fasta_nucleotide_normalizer_unit.sv -----
// top level of the fasta nucleotide normalizer: register port, front, queue, back
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------
//  byte     | byte_valid / byte_stall | byte_data  (command, in_byte)
//  res      | res_valid / res_stall   | res_data   (kind, symbol, offset, last)
//  register | psel penable pwrite     | paddr, pwdata, prdata
//
// one byte is taken per cycle while byte_stall is low; a byte makes at most one job, end of
// file makes one job that leaves as three result transfers in the back end.
// the four-entry job queue absorbs result stalls; byte_stall rises only when it is full.
// a job is registered in the queue, then its first result in the output register.
// reset clears parse state, queue and output valid; seed register to 0, length to 1.
module fasta_nucleotide_normalizer_unit import fnn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  fnn_in_t            byte_data,
	output logic               res_valid,
	input  logic               res_stall,
	output fnn_out_t           res_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [SEED_BITS-1:0]  seed_symbols_q;
	logic [SEED_LEN_W-1:0] seed_length_q;
	logic                  reg_write;

	logic       push;
	logic       pop;
	fnn_entry_t push_entry;
	fnn_entry_t head;
	fnn_qstat_t qstat;

	assign pready    = 1'b1;
	assign reg_write = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[3])
			REG_SEED_SYMBOLS: prdata = seed_symbols_q;
			default:          prdata = PDATA_W'(seed_length_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_symbols_q <= '0;
			seed_length_q  <= SEED_LEN_W'(1);
		end else if (reg_write) begin
			case (paddr[3])
				REG_SEED_SYMBOLS: seed_symbols_q <= pwdata[SEED_BITS-1:0];
				default:          seed_length_q  <= pwdata[SEED_LEN_W-1:0];
			endcase
		end
	end

	fnn_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_data    (byte_data),
		.seed_symbols (seed_symbols_q),
		.seed_length  (seed_length_q),
		.qstat        (qstat),
		.push         (push),
		.push_entry   (push_entry)
	);

	fnn_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	fnn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	// no job is written into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !qstat.full)
		else $error("job written into full queue");

	// no job is taken from an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !qstat.empty)
		else $error("job taken from empty queue");

	// the end offset transfer is always followed at once by the terminator
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && res_data.kind == KIND_END) |=>
		(res_valid && res_data.kind == KIND_SYMBOL && res_data.symbol == CHAR_DOLLAR &&
		res_data.last))
		else $error("end offset not followed by terminator");

endmodule

// ----- dv/tb.sv -----
// self-checking testbench for the fasta nucleotide normalizer unit
`timescale 1ns / 1ps

module tb;
	import fnn_pkg::*;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 10;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_pattern_t;

	// opening items: empty file, header with extreme bytes, case folding, replacements,
	// '>' inside a line, empty line, header after a filled and after an empty sequence
	localparam logic [8:0] OPENING [25] = '{
		{CMD_EOF, 8'hA5}, {CMD_BYTE, CHAR_GT}, {CMD_BYTE, 8'h00}, {CMD_BYTE, 8'hFF},
		{CMD_BYTE, CHAR_LF}, {CMD_BYTE, "a"}, {CMD_BYTE, "c"}, {CMD_BYTE, "g"},
		{CMD_BYTE, "t"}, {CMD_BYTE, CHAR_A}, {CMD_BYTE, CHAR_C}, {CMD_BYTE, CHAR_G},
		{CMD_BYTE, CHAR_T}, {CMD_BYTE, "n"}, {CMD_BYTE, 8'h80}, {CMD_BYTE, CHAR_CR},
		{CMD_BYTE, CHAR_GT}, {CMD_BYTE, CHAR_LF}, {CMD_BYTE, CHAR_LF}, {CMD_BYTE, CHAR_GT},
		{CMD_BYTE, CHAR_LF}, {CMD_BYTE, CHAR_GT}, {CMD_BYTE, CHAR_LF}, {CMD_BYTE, "z"},
		{CMD_EOF, 8'h5A}
	};

	class fasta_text_scoreboard;
		fnn_out_t pending_text[$];
		int errors;
		logic [7:0] base_of_code [4];
		logic [63:0] seed_code;
		logic [5:0] seed_len;
		bit at_line_start;
		bit in_header;
		logic [4:0] seed_pos;
		logic [31:0] text_count;
		logic [31:0] seq_start;

		function new();
			base_of_code = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T};
			seed_code = '0;
			seed_len = 6'd1;
			errors = 0;
			restart_file();
		endfunction

		function void restart_file();
			at_line_start = 1'b1;
			in_header = 1'b0;
			seed_pos = '0;
			text_count = '0;
			seq_start = '0;
		endfunction

		function void set_register(logic sel, logic [63:0] value);
			if (sel == REG_SEED_SYMBOLS)
				seed_code = value;
			else
				seed_len = value[5:0];
		endfunction

		function void add_expected(logic [1:0] kind, logic [7:0] symbol, logic [31:0] offset,
				logic last_flag);
			fnn_out_t r;
			r.kind = kind;
			r.symbol = symbol;
			r.offset = offset;
			r.last = last_flag;
			pending_text = {pending_text, r};
		endfunction

		function logic [7:0] upcase_and_seed(logic [7:0] raw);
			logic [7:0] b;
			int span;
			int pos;
			b = raw;
			if (b >= CHAR_LOW_A && b <= CHAR_LOW_Z)
				b = b - CASE_DIFF;
			if (b == CHAR_A || b == CHAR_C || b == CHAR_G || b == CHAR_T) begin
				seed_pos = '0;
				return b;
			end
			span = int'(seed_len);
			if (span == 0)
				span = 1;
			if (span > SEED_MAX)
				span = SEED_MAX;
			pos = int'(seed_pos);
			// length may have been lowered since the position was left behind
			if (pos >= span)
				pos = 0;
			b = base_of_code[seed_code[2*pos +: 2]];
			pos++;
			seed_pos = (pos >= span) ? 5'd0 : 5'(pos);
			return b;
		endfunction

		function void take_byte(fnn_in_t it);
			logic [7:0] b;
			b = it.in_byte;
			if (it.command == CMD_EOF) begin
				add_expected(KIND_START, 8'h00, seq_start, 1'b0);
				add_expected(KIND_END, 8'h00, text_count, 1'b0);
				add_expected(KIND_SYMBOL, CHAR_DOLLAR, 32'h0, 1'b1);
				restart_file();
				return;
			end
			if (in_header) begin
				if (b == CHAR_LF) begin
					in_header = 1'b0;
					at_line_start = 1'b1;
				end
				return;
			end
			if (b == CHAR_LF) begin
				at_line_start = 1'b1;
				return;
			end
			if (at_line_start && b == CHAR_GT) begin
				in_header = 1'b1;
				at_line_start = 1'b0;
				// only a sequence that produced text reports its start
				if (text_count != seq_start) begin
					add_expected(KIND_START, 8'h00, seq_start, 1'b1);
					seq_start = text_count;
				end
				return;
			end
			at_line_start = 1'b0;
			add_expected(KIND_SYMBOL, upcase_and_seed(b), 32'h0, 1'b1);
			if (text_count != '1)
				text_count = text_count + 1;
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
		endtask

		task match_result(fnn_out_t got);
			fnn_out_t want;
			if (pending_text.size() == 0) begin
				report_mismatch("unexpected result kind", 32'(got.kind), 32'h0);
				return;
			end
			want = pending_text.pop_front();
			if (got.kind !== want.kind)
				report_mismatch("kind", 32'(got.kind), 32'(want.kind));
			if (got.symbol !== want.symbol)
				report_mismatch("symbol", 32'(got.symbol), 32'(want.symbol));
			if (got.offset !== want.offset)
				report_mismatch("offset", got.offset, want.offset);
			if (got.last !== want.last)
				report_mismatch("last", 32'(got.last), 32'(want.last));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic byte_valid;
	logic byte_stall;
	fnn_in_t byte_data;
	logic res_valid;
	logic res_stall;
	fnn_out_t res_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	fasta_text_scoreboard sb;
	stall_pattern_t stall_mode;
	int stall_tick;
	int gap_max;
	int burst_left;
	int sent_items;

	fasta_nucleotide_normalizer_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(negedge clk) begin
		stall_tick <= stall_tick + 1;
		case (stall_mode)
			STALL_NONE: res_stall <= 1'b0;
			STALL_LIGHT: res_stall <= ($urandom_range(0, 99) < 25);
			STALL_PERIODIC: res_stall <= ((stall_tick % 11) < 4);
			default: res_stall <= ($urandom_range(0, 99) < 70);
		endcase
	end

	// accepted byte transfers feed the predictor, accepted result transfers are checked
	always @(posedge clk) begin
		if (arst_n && byte_valid && !byte_stall)
			sb.take_byte(byte_data);
		if (arst_n && res_valid && !res_stall)
			sb.match_result(res_data);
	end

	task automatic send_byte(input logic cmd, input logic [7:0] b);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gap_max > 0) begin
				repeat ($urandom_range(0, gap_max)) begin
					@(negedge clk);
					byte_valid <= 1'b0;
				end
			end
		end
		burst_left--;
		@(negedge clk);
		byte_valid <= 1'b1;
		byte_data <= '{command: cmd, in_byte: b};
		do @(posedge clk); while (byte_stall);
		sent_items++;
	endtask

	task automatic write_register(input logic sel, input logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(sel, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_fasta_file();
		logic [7:0] c;
		int pick;
		repeat ($urandom_range(1, 4)) begin
			if ($urandom_range(0, 5) != 0) begin
				send_byte(CMD_BYTE, CHAR_GT);
				repeat ($urandom_range(0, 8)) begin
					c = 8'($urandom_range(0, 255));
					if (c == CHAR_LF)
						c = 8'h20;
					send_byte(CMD_BYTE, c);
				end
				send_byte(CMD_BYTE, CHAR_LF);
			end
			repeat ($urandom_range(0, 3)) begin
				repeat ($urandom_range(0, 14)) begin
					pick = $urandom_range(0, 99);
					c = sb.base_of_code[$urandom_range(0, 3)];
					if (pick < 35)
						c = c | CASE_DIFF;
					else if (pick >= 85) begin
						c = 8'($urandom_range(0, 255));
						if (c == CHAR_LF)
							c = "N";
					end else if (pick >= 65)
						c = pick[0] ? "N" : "r";
					send_byte(CMD_BYTE, c);
				end
				if ($urandom_range(0, 4) == 0)
					send_byte(CMD_BYTE, CHAR_CR);
				send_byte(CMD_BYTE, CHAR_LF);
			end
		end
		// some files run on without an end, so the next one starts in mid-state
		if ($urandom_range(0, 4) != 0) begin
			send_byte(CMD_EOF, 8'($urandom));
		end
	endtask

	task automatic send_noise();
		int pick;
		repeat ($urandom_range(1, 30)) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				send_byte(CMD_EOF, 8'($urandom));
			end else if (pick < 13)
				send_byte(CMD_BYTE, CHAR_LF);
			else if (pick < 20)
				send_byte(CMD_BYTE, CHAR_GT);
			else begin
				send_byte(CMD_BYTE, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		byte_valid <= 1'b0;
		while (sb.pending_text.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int ph;
		logic [63:0] seed_plan;
		logic [5:0] len_plan;
		sb = new();
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		stall_mode = STALL_NONE;
		gap_max = 0;
		burst_left = 0;
		sent_items = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin seed_plan = '0; len_plan = 6'd1; end
				1: begin seed_plan = '1; len_plan = 6'd32; end
				2: begin seed_plan = {$urandom, $urandom}; len_plan = 6'd0; end
				3: begin seed_plan = {$urandom, $urandom}; len_plan = 6'd63; end
				4: begin seed_plan = {8{8'hE4}}; len_plan = 6'd4; end
				5: begin seed_plan = {$urandom, $urandom}; len_plan = 6'd33; end
				7: begin seed_plan = {$urandom, $urandom}; len_plan = 6'd2; end
				8: begin seed_plan = '0; len_plan = 6'd32; end
				default: begin
					seed_plan = {$urandom, $urandom};
					len_plan = 6'($urandom_range(1, 32));
				end
			endcase
			write_register(REG_SEED_SYMBOLS, seed_plan);
			write_register(REG_SEED_LENGTH, {58'h0, len_plan});
			stall_mode = stall_pattern_t'(ph % 4);
			gap_max = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 3 : 10;
			burst_left = 0;

			if (ph == 0) begin
				foreach (OPENING[i])
					send_byte(OPENING[i][8], OPENING[i][7:0]);
			end
			sent_items = 0;
			while (sent_items < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 9) < 8)
					send_fasta_file();
				else
					send_noise();
			end
			// leave the seed position deep before the next length write
			if (ph % 2 == 1) begin
				send_byte(CMD_BYTE, CHAR_LF);
				repeat ($urandom_range(4, 12)) send_byte(CMD_BYTE, "N");
			end
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/fnn_pkg.sv
design/fnn_front.sv
design/fnn_queue.sv
design/fnn_back.sv
design/fasta_nucleotide_normalizer_unit.sv
dv/tb.sv
